>>> design/k_trade_profit_dp_macros.svh
// ============================================================================
// k_trade_profit_dp assertion macros
// Shared concurrent assertion forms for the trade profit block checkers.
// ============================================================================
`ifndef K_TRADE_PROFIT_DP_MACROS_SVH
`define K_TRADE_PROFIT_DP_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define KTP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define KTP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/ktp_pkg.sv
// ============================================================================
// ktp_pkg
// Types and constants shared by the trade profit controller and datapath.
// ============================================================================
package ktp_pkg;

    // Field widths.
    localparam int PRICE_W  = 16;
    localparam int PROFIT_W = 31;
    localparam int HOLD_W   = 33;
    localparam int CFG_W    = 5;

    // Default number of trade levels kept in the state memory.
    localparam int MAX_LEVELS_DEF = 16;

    // Reset value of the trade limit register.
    localparam logic [CFG_W-1:0] MAX_TRADES_RESET = 5'd2;

    // Input item of one transfer.
    typedef struct packed {
        logic [PRICE_W-1:0] price;
        logic               last;
    } in_item_t;

    // Result item of one transfer.
    typedef struct packed {
        logic [PROFIT_W-1:0] best_profit;
        logic                end_of_sequence;
    } out_item_t;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FINISH
    } ctl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic step;
        logic emit;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic cfg_zero;
        logic last_level;
        logic out_free;
    } dp_sts_t;

endpackage

>>> design/ktp_ctrl.sv
// ============================================================================
// ktp_ctrl
// Controller that sequences one item through the trade levels.
// ============================================================================
module ktp_ctrl
    import ktp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  dp_sts_t    sts,
    output dp_cmd_t    cmd
);

    ctl_state_t state_reg;
    ctl_state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state: a zero limit skips the level walk entirely.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = sts.cfg_zero ? ST_FINISH : ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (sts.last_level)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs: datapath commands and the input stall.
    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid;
            end
            ST_RUN:
            begin
                cmd.step = 1'b1;
            end
            ST_FINISH:
            begin
                cmd.emit = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

>>> design/ktp_dp.sv
// ============================================================================
// ktp_dp
// Datapath: level state memory, shared add-compare unit and result register.
// ============================================================================
module ktp_dp
    import ktp_pkg::*;
#(
    parameter int MAX_LEVELS = MAX_LEVELS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_wdata,
    input  in_item_t         in_data,
    output logic             out_valid,
    input  logic             out_stall,
    output out_item_t        out_data,
    input  dp_cmd_t          cmd,
    output dp_sts_t          sts
);

    localparam int LVL_W = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;

    localparam logic signed [HOLD_W-1:0] HOLD_RESET = {1'b1, {(HOLD_W-1){1'b0}}};
    localparam logic signed [HOLD_W:0]   PROFIT_MAX = {{(HOLD_W-PROFIT_W+1){1'b0}},
                                                       {PROFIT_W{1'b1}}};

    typedef struct packed {
        logic signed [HOLD_W-1:0] hold;
        logic [PROFIT_W-1:0]      sold;
    } lvl_entry_t;

    // Level state memory and its per-entry valid bits.
    lvl_entry_t             mem [MAX_LEVELS];
    logic [MAX_LEVELS-1:0]  valid_reg;
    lvl_entry_t             rd_word_reg;
    logic                   rd_valid_reg;
    logic [LVL_W-1:0]       rd_addr;

    // Item registers.
    logic [CFG_W-1:0]       max_trades_reg;
    logic [PRICE_W-1:0]     price_reg;
    logic                   last_reg;
    logic [LVL_W-1:0]       lvl_reg;
    logic [LVL_W-1:0]       last_lvl_reg;
    logic [PROFIT_W-1:0]    below_reg;
    logic [PROFIT_W-1:0]    result_reg;
    logic                   out_valid_reg;
    out_item_t              out_data_reg;

    // Unit signals.
    logic                      limit_big;
    logic [LVL_W-1:0]          last_lvl_next;
    logic                      at_last;
    logic signed [HOLD_W-1:0]  cur_hold;
    logic [PROFIT_W-1:0]       cur_sold;
    logic signed [HOLD_W:0]    sell_sum;
    logic signed [HOLD_W:0]    sold_ext;
    logic [PROFIT_W-1:0]       sold_new;
    logic signed [HOLD_W-1:0]  buy_cand;
    logic signed [HOLD_W-1:0]  hold_new;
    lvl_entry_t                wr_word;

    // Trade limit register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_trades_reg <= MAX_TRADES_RESET;
        end
        else if (cfg_we)
        begin
            max_trades_reg <= cfg_wdata;
        end
    end

    // Active limit is clamped to the levels the memory holds.
    assign limit_big     = (32'(max_trades_reg) > MAX_LEVELS);
    assign last_lvl_next = limit_big ? LVL_W'(MAX_LEVELS - 1)
                                     : LVL_W'(max_trades_reg - 5'd1);
    assign at_last       = (lvl_reg == last_lvl_reg);

    // Read one level ahead of the level being updated.
    always_comb
    begin
        if (cmd.load || at_last)
        begin
            rd_addr = '0;
        end
        else
        begin
            rd_addr = lvl_reg + LVL_W'(1);
        end
    end

    // An entry never written since the last clear reads as its reset value.
    assign cur_hold = rd_valid_reg ? rd_word_reg.hold : HOLD_RESET;
    assign cur_sold = rd_valid_reg ? rd_word_reg.sold : '0;

    // Sell update: saturating add, then keep the larger profit.
    assign sell_sum = {cur_hold[HOLD_W-1], cur_hold} + $signed({2'b0, 16'(0), price_reg});
    assign sold_ext = $signed({3'b0, cur_sold});
    always_comb
    begin
        if (sell_sum > sold_ext)
        begin
            sold_new = (sell_sum > PROFIT_MAX) ? {PROFIT_W{1'b1}} : sell_sum[PROFIT_W-1:0];
        end
        else
        begin
            sold_new = cur_sold;
        end
    end

    // Buy update from the previous level's freshly sold profit.
    assign buy_cand = $signed({2'b0, below_reg}) - $signed({17'b0, price_reg});
    assign hold_new = (buy_cand > cur_hold) ? buy_cand : cur_hold;

    assign wr_word.hold = hold_new;
    assign wr_word.sold = sold_new;

    // Memory write and registered read.
    always_ff @(posedge clk)
    begin
        if (cmd.step)
        begin
            mem[lvl_reg] <= wr_word;
        end
        rd_word_reg <= mem[rd_addr];
    end

    // Valid bits: set on write, all cleared after a sequence ends.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= valid_reg[rd_addr];
            if (cmd.emit && last_reg)
            begin
                valid_reg <= '0;
            end
            else if (cmd.step)
            begin
                valid_reg[lvl_reg] <= 1'b1;
            end
        end
    end

    // Item and level walk registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            price_reg    <= in_data.price;
            last_reg     <= in_data.last;
            lvl_reg      <= '0;
            last_lvl_reg <= last_lvl_next;
            below_reg    <= '0;
            result_reg   <= '0;
        end
        else if (cmd.step)
        begin
            lvl_reg    <= lvl_reg + LVL_W'(1);
            below_reg  <= sold_new;
            result_reg <= sold_new;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_data_reg.best_profit     <= result_reg;
            out_data_reg.end_of_sequence <= last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Status to the controller.
    assign sts.cfg_zero   = (max_trades_reg == '0);
    assign sts.last_level = at_last;
    assign sts.out_free   = !out_valid_reg || !out_stall;

endmodule

>>> design/k_trade_profit_dp.sv
// Result path: a result enters the output register once its item has walked the active trade
// levels (max_trades clamped to MAX_LEVELS), later only while the output is stalled.
// Items: one at a time; the input stays stalled until the previous result is emitted, and the one
// add-compare unit updates one trade level per cycle from the single state memory.
// Reset: max_trades returns to 2 and all level valid bits clear, so state reads reset values.
// ============================================================================
// k_trade_profit_dp
// Best stock trading profit with a configurable limit on buy-sell transactions.
// ============================================================================
module k_trade_profit_dp
    import ktp_pkg::*;
#(
    parameter int MAX_LEVELS = MAX_LEVELS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_wdata,
    input  logic             in_valid,
    output logic             in_stall,
    input  in_item_t         in_data,
    output logic             out_valid,
    input  logic             out_stall,
    output out_item_t        out_data
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    // Sequencing of the level walk.
    ktp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // State memory, arithmetic and result register.
    ktp_dp #(
        .MAX_LEVELS (MAX_LEVELS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

>>> design/ktp_checker.sv
// ============================================================================
// ktp_checker
// Port-level checks on the trade profit block, bound to the top level.
// ============================================================================
`include "k_trade_profit_dp_macros.svh"

module ktp_checker
    import ktp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_stall,
    input  logic      out_valid,
    input  logic      out_stall,
    input  out_item_t out_data
);

    // A stalled result holds until its transfer.
    `KTP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")

    // One item at a time: an input transfer must be followed by a closed input.
    `KTP_ASSERT_NEXT(a_in_busy, clk, rst_n, in_valid && !in_stall, in_stall, "input open right after a transfer")

    // A new result appears only as the block finishes an item and reopens its input.
    `KTP_ASSERT_IMPL(a_out_rise, clk, rst_n, $rose(out_valid), $past(in_stall) && !in_stall, "result without a finished item")

endmodule

bind k_trade_profit_dp ktp_checker u_ktp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
